// ===== sv/d8fd_pkg.sv =====
// ----------------------------------------------------------------------------
// d8fd_pkg: shared definitions of the D8 flow direction core
// Field widths, register indexes, direction codes, the context that travels
// with each sample down the pipeline, and the edge code rule.
// ----------------------------------------------------------------------------
package d8fd_pkg;

  localparam int DEF_MAX_COLUMNS = 4096;
  localparam int DEF_ELEV_BITS   = 32;

  localparam int ROW_W      = 16;
  localparam int COL_CFG_W  = 13;
  localparam int COL_OUT_W  = 12;
  localparam int DIR_BITS   = 4;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 32;
  localparam int OUT_DATA_W = 32;

  localparam logic [CFG_IDX_W-1:0] REG_ROW_COUNT    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_COLUMN_COUNT = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_NODATA_VALUE = 2'd2;

  localparam logic [ROW_W-1:0]      ROW_COUNT_RST    = 16'd1;
  localparam logic [COL_CFG_W-1:0]  COLUMN_COUNT_RST = 13'd1;
  localparam logic [CFG_DATA_W-1:0] NODATA_RST       = 32'hFFFF_D8F1;

  localparam logic [DIR_BITS-1:0] DIR_NONE  = 4'd0;
  localparam logic [DIR_BITS-1:0] DIR_WEST  = 4'd1;
  localparam logic [DIR_BITS-1:0] DIR_NW    = 4'd2;
  localparam logic [DIR_BITS-1:0] DIR_NORTH = 4'd3;
  localparam logic [DIR_BITS-1:0] DIR_NE    = 4'd4;
  localparam logic [DIR_BITS-1:0] DIR_EAST  = 4'd5;
  localparam logic [DIR_BITS-1:0] DIR_SE    = 4'd6;
  localparam logic [DIR_BITS-1:0] DIR_SOUTH = 4'd7;
  localparam logic [DIR_BITS-1:0] DIR_SW    = 4'd8;

  // Results a sample can release, bit 0 first:
  // the lagging cell, the right-edge cell of the row above, the bottom cell.
  typedef struct packed {
    logic [ROW_W-1:0]     row;
    logic [COL_CFG_W-1:0] col;
    logic [2:0]           mask;
    logic [DIR_BITS-1:0]  side_a;
    logic [DIR_BITS-1:0]  code_b;
    logic [DIR_BITS-1:0]  code_c;
  } d8fd_ctx_t;

  typedef struct packed {
    logic [DIR_BITS-1:0]  direction;
    logic [COL_OUT_W-1:0] cell_column;
    logic [ROW_W-1:0]     cell_row;
  } d8fd_result_t;

  // Fixed code of a raster edge cell, DIR_NONE for an interior cell.
  function automatic logic [DIR_BITS-1:0] side_code(input logic top, input logic bottom,
                                                    input logic left, input logic right);
    logic [DIR_BITS-1:0] code;
    if (top && left)         code = DIR_NW;
    else if (bottom && left) code = DIR_SW;
    else if (top && right)   code = DIR_NE;
    else if (bottom && right) code = DIR_SE;
    else if (left)           code = DIR_WEST;
    else if (right)          code = DIR_EAST;
    else if (top)            code = DIR_NORTH;
    else if (bottom)         code = DIR_SOUTH;
    else                     code = DIR_NONE;
    return code;
  endfunction

endpackage

// ===== sv/d8_flow_direction_core.sv =====
// ----------------------------------------------------------------------------
// d8_flow_direction_core: streaming D8 flow direction over a raster
// Throughput: one sample per cycle while m_tready is high; a sample that releases
// two or three results stalls the input while the single output register sends them.
// Reset: synchronous; clears position and pipeline and restores the register
// defaults; the line buffer memory is not cleared, every entry is written
// before it is used.
// ----------------------------------------------------------------------------
module d8_flow_direction_core import d8fd_pkg::*; #(
  parameter int MAX_COLUMNS    = DEF_MAX_COLUMNS,
  parameter int ELEVATION_BITS = DEF_ELEV_BITS,
  localparam int TDATA_W       = ((ELEVATION_BITS + 7) / 8) * 8
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  s_tvalid,
  output logic                  s_tready,
  input  logic [TDATA_W-1:0]    s_tdata,    // elevation
  output logic                  m_tvalid,
  input  logic                  m_tready,
  output logic [OUT_DATA_W-1:0] m_tdata,    // cell_row, cell_column, direction
  output logic                  m_tlast,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  localparam int EW = ELEVATION_BITS;
  localparam int AW = (MAX_COLUMNS > 1) ? $clog2(MAX_COLUMNS) : 1;

  logic [ROW_W-1:0]      row_count;
  logic [COL_CFG_W-1:0]  column_count;
  logic [CFG_DATA_W-1:0] nodata_value;

  logic [ROW_W-1:0]      rows_eff;
  logic [COL_CFG_W-1:0]  cols_nz;
  logic [COL_CFG_W-1:0]  cols_eff;
  logic [EW-1:0]         nodata_ext;

  logic [COL_CFG_W-1:0]  col_pos;
  logic [ROW_W-1:0]      row_pos;
  logic [COL_CFG_W-1:0]  col_pos_next;
  logic [ROW_W-1:0]      row_pos_next;
  logic                  col_wrap;
  logic [COL_CFG_W-1:0]  c_cur;
  logic [ROW_W:0]        row_step;
  logic [ROW_W-1:0]      r_cur;
  logic [COL_CFG_W:0]    c_inc;
  logic [ROW_W:0]        r_inc;
  logic                  accept;

  logic                  s1_valid;
  logic signed [EW-1:0]  s1_raw;
  logic [ROW_W-1:0]      s1_r;
  logic [COL_CFG_W-1:0]  s1_c;
  logic                  s1_fwd;
  logic signed [EW-1:0]  s1_fwd_upper;
  logic signed [EW-1:0]  s1_fwd_middle;
  logic signed [EW-1:0]  s1_upper;
  logic signed [EW-1:0]  s1_middle;
  logic [2*EW-1:0]       rd_data;
  d8fd_ctx_t             s1_ctx;
  logic                  s1_last_col;

  logic                  win_ready;
  logic                  dir_valid;
  logic                  emit_ready;
  d8fd_ctx_t             dir_ctx;
  logic [DIR_BITS-1:0]   dir_a;
  d8fd_result_t          result;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      row_count    <= ROW_COUNT_RST;
      column_count <= COLUMN_COUNT_RST;
      nodata_value <= NODATA_RST;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        REG_ROW_COUNT:    row_count    <= cfg_data[ROW_W-1:0];
        REG_COLUMN_COUNT: column_count <= cfg_data[COL_CFG_W-1:0];
        REG_NODATA_VALUE: nodata_value <= cfg_data;
        default: ;
      endcase
    end
  end

  // A count of zero acts as one; the column count is capped at the buffer depth.
  always_comb begin
    rows_eff   = (row_count == '0) ? ROW_W'(1) : row_count;
    cols_nz    = (column_count == '0) ? COL_CFG_W'(1) : column_count;
    cols_eff   = (32'(cols_nz) > 32'(MAX_COLUMNS)) ? COL_CFG_W'(MAX_COLUMNS) : cols_nz;
    nodata_ext = EW'($signed(nodata_value));
  end

  // A position left outside a smaller frame by a register write wraps first.
  always_comb begin
    col_wrap = (col_pos >= cols_eff);
    c_cur    = col_wrap ? '0 : col_pos;
    row_step = {1'b0, row_pos} + (ROW_W + 1)'(col_wrap);
    r_cur    = (row_step >= {1'b0, rows_eff}) ? '0 : row_step[ROW_W-1:0];
    c_inc    = {1'b0, c_cur} + (COL_CFG_W + 1)'(1);
    r_inc    = {1'b0, r_cur} + (ROW_W + 1)'(1);
    if (c_inc >= {1'b0, cols_eff}) begin
      col_pos_next = '0;
      row_pos_next = (r_inc >= {1'b0, rows_eff}) ? '0 : r_inc[ROW_W-1:0];
    end else begin
      col_pos_next = c_inc[COL_CFG_W-1:0];
      row_pos_next = r_cur;
    end
  end

  assign s_tready = !s1_valid || win_ready;
  assign accept   = s_tvalid && s_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      col_pos  <= '0;
      row_pos  <= '0;
      s1_valid <= 1'b0;
    end else begin
      if (s_tready) begin
        s1_valid <= s_tvalid;
      end
      if (accept) begin
        col_pos <= col_pos_next;
        row_pos <= row_pos_next;
      end
    end
  end

  // The sample leaving the first stage writes the entry that the arriving one
  // reads in the same cycle; its write data is forwarded instead.
  always_ff @(posedge clk) begin
    if (accept) begin
      s1_raw        <= s_tdata[EW-1:0];
      s1_r          <= r_cur;
      s1_c          <= c_cur;
      s1_fwd        <= s1_valid && (s1_c == c_cur);
      s1_fwd_upper  <= s1_middle;
      s1_fwd_middle <= s1_raw;
    end
  end

  d8fd_line_buffer #(
    .DEPTH  (MAX_COLUMNS),
    .DATA_W (2 * EW)
  ) u_line_buffer (
    .clk     (clk),
    .wr_en   (s1_valid && win_ready),
    .wr_addr (AW'(s1_c)),
    .wr_data ({s1_raw, s1_middle}),
    .rd_en   (accept),
    .rd_addr (AW'(c_cur)),
    .rd_data (rd_data)
  );

  always_comb begin
    s1_upper    = s1_fwd ? s1_fwd_upper  : $signed(rd_data[EW-1:0]);
    s1_middle   = s1_fwd ? s1_fwd_middle : $signed(rd_data[2*EW-1:EW]);
    s1_last_col = (s1_c == cols_eff - COL_CFG_W'(1));

    s1_ctx.row     = s1_r;
    s1_ctx.col     = s1_c;
    s1_ctx.mask[0] = (s1_r != '0) && (s1_c != '0);
    s1_ctx.mask[1] = (s1_r != '0) && s1_last_col;
    s1_ctx.mask[2] = (s1_r == rows_eff - ROW_W'(1));
    s1_ctx.side_a  = side_code(s1_r == ROW_W'(1), s1_r == rows_eff,
                               s1_c == COL_CFG_W'(1), s1_c == cols_eff);
    s1_ctx.code_b  = (s1_middle == $signed(nodata_ext)) ? DIR_NONE :
                     side_code(s1_r == ROW_W'(1), s1_r == rows_eff, s1_c == '0, 1'b1);
    s1_ctx.code_c  = (s1_raw == $signed(nodata_ext)) ? DIR_NONE :
                     side_code(s1_r == '0, 1'b1, s1_c == '0, s1_last_col);
  end

  d8fd_window_dir #(
    .EW (EW)
  ) u_window_dir (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s1_valid),
    .in_ready  (win_ready),
    .in_ctx    (s1_ctx),
    .upper     (s1_upper),
    .middle    (s1_middle),
    .raw       (s1_raw),
    .nodata    (nodata_ext),
    .out_valid (dir_valid),
    .out_ready (emit_ready),
    .out_ctx   (dir_ctx),
    .out_dir_a (dir_a)
  );

  d8fd_emit u_emit (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (dir_valid),
    .in_ready   (emit_ready),
    .in_ctx     (dir_ctx),
    .in_dir_a   (dir_a),
    .out_valid  (m_tvalid),
    .out_ready  (m_tready),
    .out_result (result),
    .out_last   (m_tlast)
  );

  assign m_tdata = result;

endmodule

// ===== sv/d8fd_line_buffer.sv =====
// ----------------------------------------------------------------------------
// d8fd_line_buffer: two raster lines in one synchronous memory
// Each word holds the newer line in the upper half and the older line in the
// lower half. Read data is registered and held while no read is issued.
// ----------------------------------------------------------------------------
module d8fd_line_buffer import d8fd_pkg::*; #(
  parameter int DEPTH  = DEF_MAX_COLUMNS,
  parameter int DATA_W = 2 * DEF_ELEV_BITS,
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic              clk,
  input  logic              wr_en,
  input  logic [AW-1:0]     wr_addr,
  input  logic [DATA_W-1:0] wr_data,
  input  logic              rd_en,
  input  logic [AW-1:0]     rd_addr,
  output logic [DATA_W-1:0] rd_data
);

  logic [DATA_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// ===== sv/d8fd_window_dir.sv =====
// ----------------------------------------------------------------------------
// d8fd_window_dir: 3x3 window and steepest-descent search
// The window shifts once per sample. A registered minimum tree finds the
// lowest neighbor; the last stage picks the first cardinal neighbor at that
// height, else the first neighbor at that height.
// ----------------------------------------------------------------------------
module d8fd_window_dir import d8fd_pkg::*; #(
  parameter int EW = DEF_ELEV_BITS
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  d8fd_ctx_t           in_ctx,
  input  logic signed [EW-1:0] upper,
  input  logic signed [EW-1:0] middle,
  input  logic signed [EW-1:0] raw,
  input  logic [EW-1:0]       nodata,
  output logic                out_valid,
  input  logic                out_ready,
  output d8fd_ctx_t           out_ctx,
  output logic [DIR_BITS-1:0] out_dir_a
);

  logic signed [EW-1:0] win [3][3];
  logic                 s2_valid;
  d8fd_ctx_t            s2_ctx;
  logic                 s2_ready;
  logic signed [EW-1:0] nb [8];
  logic signed [EW-1:0] lvl1 [4];
  logic signed [EW-1:0] m01;
  logic signed [EW-1:0] m23;

  logic                 s3_valid;
  logic                 s3_ready;
  d8fd_ctx_t            s3_ctx;
  logic signed [EW-1:0] s3_nb [8];
  logic signed [EW-1:0] s3_self;
  logic                 s3_self_nodata;
  logic signed [EW-1:0] s3_m01;
  logic signed [EW-1:0] s3_m23;

  logic                 pick01;
  logic                 lower;
  logic [7:0]           eq;
  logic [DIR_BITS-1:0]  scan_dir;

  assign s2_ready = !s2_valid || s3_ready;
  assign s3_ready = !s3_valid || out_ready;
  assign in_ready = s2_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid <= 1'b0;
      s3_valid <= 1'b0;
    end else begin
      if (s2_ready) begin
        s2_valid <= in_valid;
      end
      if (s3_ready) begin
        s3_valid <= s2_valid;
      end
    end
  end

  // The window is part of the second stage: it moves only when a sample enters.
  always_ff @(posedge clk) begin
    if (in_valid && s2_ready) begin
      for (int i = 0; i < 3; i++) begin
        win[i][0] <= win[i][1];
        win[i][1] <= win[i][2];
      end
      win[0][2] <= upper;
      win[1][2] <= middle;
      win[2][2] <= raw;
      s2_ctx    <= in_ctx;
    end
  end

  // Neighbors in code order W, NW, N, NE, E, SE, S, SW.
  always_comb begin
    nb[0] = win[1][0];
    nb[1] = win[0][0];
    nb[2] = win[0][1];
    nb[3] = win[0][2];
    nb[4] = win[1][2];
    nb[5] = win[2][2];
    nb[6] = win[2][1];
    nb[7] = win[2][0];
    for (int i = 0; i < 4; i++) begin
      lvl1[i] = (nb[2*i] < nb[2*i+1]) ? nb[2*i] : nb[2*i+1];
    end
    m01 = (lvl1[0] < lvl1[1]) ? lvl1[0] : lvl1[1];
    m23 = (lvl1[2] < lvl1[3]) ? lvl1[2] : lvl1[3];
  end

  always_ff @(posedge clk) begin
    if (s2_valid && s3_ready) begin
      s3_ctx         <= s2_ctx;
      s3_nb          <= nb;
      s3_self        <= win[1][1];
      s3_self_nodata <= (win[1][1] == $signed(nodata));
      s3_m01         <= m01;
      s3_m23         <= m23;
    end
  end

  // The whole minimum set is checked in parallel against whichever half won.
  always_comb begin
    pick01 = (s3_m01 <= s3_m23);
    lower  = (s3_m01 < s3_self) || (s3_m23 < s3_self);
    for (int i = 0; i < 8; i++) begin
      eq[i] = pick01 ? (s3_nb[i] == s3_m01) : (s3_nb[i] == s3_m23);
    end
    scan_dir = DIR_NONE;
    for (int i = 7; i >= 0; i--) begin
      if (eq[i]) scan_dir = DIR_BITS'(i + 1);
    end
    // Cardinal neighbors sit at even indexes and win over diagonals.
    for (int i = 6; i >= 0; i -= 2) begin
      if (eq[i]) scan_dir = DIR_BITS'(i + 1);
    end
    if (s3_self_nodata) begin
      out_dir_a = DIR_NONE;
    end else if (s3_ctx.side_a != DIR_NONE) begin
      out_dir_a = s3_ctx.side_a;
    end else if (lower) begin
      out_dir_a = scan_dir;
    end else begin
      out_dir_a = DIR_NONE;
    end
  end

  assign out_valid = s3_valid;
  assign out_ctx   = s3_ctx;

endmodule

// ===== sv/d8fd_emit.sv =====
// ----------------------------------------------------------------------------
// d8fd_emit: result serializer and output register
// Holds one sample's context and sends its zero to three results in order,
// one per cycle while out_ready is high, through a registered output stage.
// ----------------------------------------------------------------------------
module d8fd_emit import d8fd_pkg::*; (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  d8fd_ctx_t           in_ctx,
  input  logic [DIR_BITS-1:0] in_dir_a,
  output logic                out_valid,
  input  logic                out_ready,
  output d8fd_result_t        out_result,
  output logic                out_last
);

  logic                 held;
  logic [2:0]           mask;
  logic [ROW_W-1:0]     row;
  logic [COL_CFG_W-1:0] col;
  logic [DIR_BITS-1:0]  dir_a;
  logic [DIR_BITS-1:0]  code_b;
  logic [DIR_BITS-1:0]  code_c;

  logic                 out_load;
  logic                 emit;
  logic [2:0]           remaining;
  d8fd_result_t         pick;

  always_comb begin
    priority if (mask[0]) begin
      pick.cell_row    = row - ROW_W'(1);
      pick.cell_column = COL_OUT_W'(col - COL_CFG_W'(1));
      pick.direction   = dir_a;
      remaining        = {mask[2:1], 1'b0};
    end else if (mask[1]) begin
      pick.cell_row    = row - ROW_W'(1);
      pick.cell_column = COL_OUT_W'(col);
      pick.direction   = code_b;
      remaining        = {mask[2], 2'b00};
    end else begin
      pick.cell_row    = row;
      pick.cell_column = COL_OUT_W'(col);
      pick.direction   = code_c;
      remaining        = 3'b000;
    end
  end

  assign out_load = !out_valid || out_ready;
  assign emit     = held && (mask != 3'b000) && out_load;
  assign in_ready = !held || (mask == 3'b000) || (emit && (remaining == 3'b000));

  always_ff @(posedge clk) begin
    if (rst) begin
      held      <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (in_ready) begin
        held <= in_valid;
      end
      if (out_load) begin
        out_valid <= emit;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      mask   <= in_ctx.mask;
      row    <= in_ctx.row;
      col    <= in_ctx.col;
      dir_a  <= in_dir_a;
      code_b <= in_ctx.code_b;
      code_c <= in_ctx.code_c;
    end else if (emit) begin
      mask <= remaining;
    end
    if (emit) begin
      out_result <= pick;
      out_last   <= (remaining == 3'b000);
    end
  end

endmodule
